### design/mp2a_pkg.sv
package mp2a_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 11;
  localparam int WINDOW_CFG_BITS = 3;

  // Position fields of a result word
  localparam int POS_BITS   = 10;
  localparam int MAX_HEIGHT = 1024;

  // Register reset values
  localparam logic [CFG_DATA_BITS-1:0]   RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [CFG_DATA_BITS-1:0]   RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [WINDOW_CFG_BITS-1:0] RST_WINDOW_SIZE  = 3'd2;

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_WINDOW_SIZE  = 2'd2
  } cfg_reg_e;

endpackage

### design/mp2a_in_if.sv
interface mp2a_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### design/mp2a_out_if.sv
interface mp2a_out_if #(
  parameter int SAMPLE_BITS = 16
);
  import mp2a_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] win_max;
  logic [POS_BITS-1:0]           max_row;
  logic [POS_BITS-1:0]           max_col;
  logic                          plane_last;

  modport source (output valid, output win_max, output max_row, output max_col,
                  output plane_last, input ready);
  modport sink   (input valid, input win_max, input max_row, input max_col,
                  input plane_last, output ready);
endinterface

### design/mp2a_cfg_if.sv
interface mp2a_cfg_if;
  import mp2a_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/mp2a_argmax.sv
module mp2a_argmax #(
  parameter int MAX_WINDOW  = 4,
  parameter int SAMPLE_BITS = 16,
  localparam int KW = $clog2(MAX_WINDOW + 1),
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic signed [SAMPLE_BITS-1:0] win_i [MAX_WINDOW][MAX_WINDOW],
  input  logic [KW-1:0]                 k_i,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output logic [IW-1:0]                 row_o,
  output logic [IW-1:0]                 col_o
);

  localparam int N     = MAX_WINDOW * MAX_WINDOW;
  localparam int P     = 1 << $clog2(N);
  localparam int NODES = 2 * P - 1;

  logic signed [SAMPLE_BITS-1:0] nv [NODES];
  logic                          nk [NODES];
  logic [IW-1:0]                 nr [NODES];
  logic [IW-1:0]                 nc [NODES];
  logic [KW-1:0]                 base;

  // The active window sits in the bottom-right corner of the register array
  assign base = KW'(MAX_WINDOW) - k_i;

  // Heap-ordered compare tree; left child always covers earlier scan positions,
  // so a tie keeps the left candidate and the first sample in scan order wins
  always_comb begin
    for (int n = 0; n < P; n++) begin
      if (n < N) begin
        nv[P-1+n] = win_i[n / MAX_WINDOW][n % MAX_WINDOW];
        nr[P-1+n] = IW'(n / MAX_WINDOW);
        nc[P-1+n] = IW'(n % MAX_WINDOW);
        nk[P-1+n] = (KW'(n / MAX_WINDOW) >= base) && (KW'(n % MAX_WINDOW) >= base);
      end else begin
        nv[P-1+n] = '0;
        nr[P-1+n] = '0;
        nc[P-1+n] = '0;
        nk[P-1+n] = 1'b0;
      end
    end
    for (int n = P - 2; n >= 0; n--) begin
      if (nk[2*n+2] && (!nk[2*n+1] || (nv[2*n+2] > nv[2*n+1]))) begin
        nv[n] = nv[2*n+2];
        nr[n] = nr[2*n+2];
        nc[n] = nc[2*n+2];
        nk[n] = 1'b1;
      end else begin
        nv[n] = nv[2*n+1];
        nr[n] = nr[2*n+1];
        nc[n] = nc[2*n+1];
        nk[n] = nk[2*n+1];
      end
    end
  end

  assign value_o = nv[0];
  assign row_o   = nr[0];
  assign col_o   = nc[0];

endmodule

### design/max_pool_2d_argmax_core.sv
// Streaming 2-D max pooling with argmax, stride 1, no padding.
//
// in_i carries one sample word per pixel in raster order, plane after plane.
// out_o carries one result word for each pixel at which a full KxK window
// ends: the window maximum, its row and column within the plane, and a flag on
// the last window of the plane. Ties go to the earliest sample in scan order.
// cfg_i writes image_width (0), image_height (1) and window_size (2); it is
// always ready, and a write to a known index restarts the plane at row 0,
// column 0. Write it only while no words are in flight.
//
// A sample passes the line-store read register, the window shift and the compare
// tree into the output register, which drives out_o.valid.
// Throughput: one sample per cycle unless out_o stalls; the line store is a
// single memory with one read and one write per cycle, and back-to-back reuse
// of a column (width 1) is covered by a bypass.
// A stalled receiver holds the output register; the pipeline behind it keeps
// filling until every stage is full and then in_i.ready drops.
// Reset clears the counters and the valid flags and loads the register reset
// values; the line store is not cleared and no pixel waits on it.
module max_pool_2d_argmax_core #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_WINDOW  = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mp2a_in_if.sink     in_i,
  mp2a_out_if.source  out_o,
  mp2a_cfg_if.sink    cfg_i
);
  import mp2a_pkg::*;

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int KW       = $clog2(MAX_WINDOW + 1);
  localparam int IW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LINE_CNT = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;

  typedef logic [LINE_CNT-1:0][SAMPLE_BITS-1:0] line_word_t;

  // Configuration registers
  logic [CFG_DATA_BITS-1:0]   width_q, height_q;
  logic [WINDOW_CFG_BITS-1:0] wsize_q;
  logic                       cfg_wr;
  logic                       restart;

  // Effective geometry
  logic [CW:0]           w_eff;
  logic [CW-1:0]         c_last;
  logic [POS_BITS-1:0]   h_last;
  logic [KW-1:0]         k_eff;
  logic [KW-1:0]         km1;

  // Position counters
  logic [CW-1:0]         col_count_q, col_count_d;
  logic [POS_BITS-1:0]   row_count_q, row_count_d;
  logic [CW-1:0]         c_cur;
  logic [POS_BITS-1:0]   r_cur;

  // Stage 1: sample waiting on its line-store read
  logic                          in_acc;
  logic                          in_ready;
  logic                          v1_q;
  logic signed [SAMPLE_BITS-1:0] s1_q;
  logic [CW-1:0]                 c1_q;
  logic [POS_BITS-1:0]           r1_q;
  logic                          emit1_q;
  logic                          last1_q;
  line_word_t                    rd_q;
  line_word_t                    fwdd_q;
  logic                          fwd_q;
  line_word_t                    line_word;
  line_word_t                    wr_word;
  logic                          s1_fire;

  line_word_t line_mem_q [MAX_WIDTH];

  // Window and pending result
  logic signed [SAMPLE_BITS-1:0] win_q [MAX_WINDOW][MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] col_in [MAX_WINDOW];
  logic                          pv_q;
  logic [POS_BITS-1:0]           prow_q, pcol_q;
  logic                          plast_q;
  logic                          p_adv;

  // Output register
  logic                          ov_q;
  logic signed [SAMPLE_BITS-1:0] oval_q;
  logic [POS_BITS-1:0]           orow_q, ocol_q;
  logic                          olast_q;

  logic signed [SAMPLE_BITS-1:0] am_value;
  logic [IW-1:0]                 am_row, am_col;

  // Configuration writes
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_comb begin
    case (cfg_reg_e'(cfg_i.index))
      REG_IMAGE_WIDTH:  restart = cfg_wr;
      REG_IMAGE_HEIGHT: restart = cfg_wr;
      REG_WINDOW_SIZE:  restart = cfg_wr;
      default:          restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      wsize_q  <= RST_WINDOW_SIZE;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
        REG_IMAGE_HEIGHT: height_q <= cfg_i.data;
        REG_WINDOW_SIZE:  wsize_q  <= WINDOW_CFG_BITS'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Clamp the registers into their usable ranges
  always_comb begin
    if (width_q == '0) begin
      w_eff = (CW+1)'(1);
    end else if (width_q > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(width_q);
    end
    c_last = CW'(w_eff - (CW+1)'(1));

    if (height_q == '0) begin
      h_last = '0;
    end else if (height_q > MAX_HEIGHT) begin
      h_last = POS_BITS'(MAX_HEIGHT - 1);
    end else begin
      h_last = POS_BITS'(height_q - 11'd1);
    end

    if (wsize_q == '0) begin
      k_eff = KW'(1);
    end else if (wsize_q > MAX_WINDOW) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(wsize_q);
    end
    km1 = k_eff - KW'(1);
  end

  // Current pixel position and counter advance
  always_comb begin
    c_cur = (col_count_q > c_last) ? c_last : col_count_q;
    r_cur = (row_count_q > h_last) ? h_last : row_count_q;
    col_count_d = col_count_q;
    row_count_d = row_count_q;
    if (restart) begin
      col_count_d = '0;
      row_count_d = '0;
    end else if (in_acc) begin
      if (c_cur == c_last) begin
        col_count_d = '0;
        row_count_d = (r_cur == h_last) ? '0 : r_cur + POS_BITS'(1);
      end else begin
        col_count_d = c_cur + CW'(1);
        row_count_d = r_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
    end
  end

  // Handshake between stages
  assign p_adv    = pv_q && (!ov_q || out_o.ready);
  assign s1_fire  = v1_q && (!pv_q || p_adv);
  assign in_ready = !v1_q || s1_fire;
  assign in_acc   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      if (in_acc) begin
        v1_q  <= 1'b1;
        fwd_q <= s1_fire && (c_cur == c1_q);
      end else if (s1_fire) begin
        v1_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q    <= in_i.sample;
      c1_q    <= c_cur;
      r1_q    <= r_cur;
      emit1_q <= (r_cur >= km1) && (c_cur >= km1);
      last1_q <= (r_cur == h_last) && (c_cur == c_last);
      fwdd_q  <= wr_word;
    end
  end

  // Line store: one read at acceptance, one write when the word moves on
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= line_mem_q[c_cur];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem_q[c1_q] <= wr_word;
    end
  end

  // Older lines shift down one slot; newest sample enters line 0
  always_comb begin
    line_word  = fwd_q ? fwdd_q : rd_q;
    wr_word[0] = s1_q;
    for (int l = 1; l < LINE_CNT; l++) begin
      wr_word[l] = line_word[l-1];
    end
    for (int i = 0; i < MAX_WINDOW - 1; i++) begin
      col_in[i] = line_word[MAX_WINDOW-2-i];
    end
    col_in[MAX_WINDOW-1] = s1_q;
  end

  // Window shift: columns move left, new column enters on the right
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        for (int j = 0; j + 1 < MAX_WINDOW; j++) begin
          win_q[i][j] <= win_q[i][j+1];
        end
        win_q[i][MAX_WINDOW-1] <= col_in[i];
      end
    end
  end

  // Pending result: base position of the window's top-left register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (s1_fire) begin
      pv_q <= emit1_q;
    end else if (p_adv) begin
      pv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      prow_q  <= r1_q + POS_BITS'(1) - POS_BITS'(MAX_WINDOW);
      pcol_q  <= POS_BITS'(c1_q) + POS_BITS'(1) - POS_BITS'(MAX_WINDOW);
      plast_q <= last1_q;
    end
  end

  mp2a_argmax #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_argmax (
    .win_i   (win_q),
    .k_i     (k_eff),
    .value_o (am_value),
    .row_o   (am_row),
    .col_o   (am_col)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (p_adv) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_adv) begin
      oval_q  <= am_value;
      orow_q  <= prow_q + POS_BITS'(am_row);
      ocol_q  <= pcol_q + POS_BITS'(am_col);
      olast_q <= plast_q;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.win_max    = oval_q;
  assign out_o.max_row    = orow_q;
  assign out_o.max_col    = ocol_q;
  assign out_o.plane_last = olast_q;

  // Checks
  a_counters_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_count_q <= c_last) && (row_count_q <= h_last))
    else $error("position counter beyond plane");

  a_bypass_only_width_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && fwd_q) |-> (c_last == '0))
    else $error("line-store bypass taken with width above one");

  a_pending_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv_q && !p_adv) |=> (pv_q && $stable(prow_q) && $stable(pcol_q)))
    else $error("pending result lost while output stalled");

  a_out_from_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(pv_q))
    else $error("result word without a pending window");

endmodule
